// File: rtl/cqg_pkg.sv
// cqg_pkg: types, codes and constants of the controlled one-qubit gate block
// no dependencies
`timescale 1ns / 1ps
package cqg_pkg;

  localparam int AMP_W  = 16;
  localparam int ADDR_W = 10;
  localparam int CTRL_W = 10;
  localparam int GATE_W = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_APPLY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_APPLY  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_QUBITS = 3'd0,
    REG_TARGET     = 3'd1,
    REG_CTRL_MASK  = 3'd2,
    REG_CTRL_VALUE = 3'd3,
    REG_GATE_M00   = 3'd4,
    REG_GATE_M01   = 3'd5,
    REG_GATE_M10   = 3'd6,
    REG_GATE_M11   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_RD0,
    S_RD1,
    S_CALC,
    S_WR1
  } state_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [ADDR_W-1:0]       address;
    logic signed [AMP_W-1:0] in_re;
    logic signed [AMP_W-1:0] in_im;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [AMP_W-1:0] out_re;
    logic signed [AMP_W-1:0] out_im;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] im;
    logic signed [AMP_W-1:0] re;
  } amp_t;

  typedef struct packed {
    amp_t q0;
    amp_t q1;
    logic sat;
  } mac_res_t;

  localparam logic [GATE_W-1:0] GATE_DIAG_RESET = 32'h7FFF_7FFF;

endpackage

// File: rtl/controlled_one_qubit_gate_apply_top.sv
// controlled_one_qubit_gate_apply_top: command sequencer, config registers, result register
// write, rejected apply: result loaded as the command is taken; read: loaded in S_READ
// apply: scans indices below 2^num_qubits; each selected pair is read, updated and stored,
//   paced by the shared multiplier (16 products) and the single read port of the store
// commands: one at a time; next taken when idle and the result register is empty or read
// reset: synchronous active low, sets control and config registers to reset values; store is not cleared
// depends on cqg_pkg, cqg_ram, cqg_mac
`timescale 1ns / 1ps
module controlled_one_qubit_gate_apply_top #(
  parameter int LOG_AMPS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cqg_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cqg_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cqg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cqg_pkg::GATE_W-1:0]      cfg_data
);
  import cqg_pkg::*;

  localparam int IW = LOG_AMPS + 1;
  localparam int MW = (IW > CTRL_W) ? IW : CTRL_W;

  state_t              state_r, state_nxt;
  logic [3:0]          nq_r, tgt_r;
  logic [CTRL_W-1:0]   cmask_r, cval_r;
  logic [GATE_W-1:0]   m00_r, m01_r, m10_r, m11_r;
  logic [IW-1:0]       idx_r;
  amp_t                a0_r;
  logic                sat_r;
  logic                out_valid_r;
  out_item_t           out_r, out_nxt;
  logic                out_load;

  logic                out_free, accept, reject, scan_end, qualify;
  logic [MW-1:0]       idx_x, tbit, mask, want, pair_x, addr_x;
  logic                ram_we;
  logic [LOG_AMPS-1:0] ram_wa, ram_ra;
  amp_t                ram_wd, ram_rd;
  logic                mac_start, mac_done;
  mac_res_t            mac_res;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign reject   = (32'(nq_r) > LOG_AMPS) || (tgt_r >= nq_r);
  assign idx_x    = MW'(idx_r);
  assign tbit     = MW'(1) << tgt_r;
  assign mask     = MW'(cmask_r) & ~tbit;
  assign want     = MW'(cval_r) & mask;
  assign pair_x   = idx_x | tbit;
  assign addr_x   = MW'(in_data.address);
  assign scan_end = idx_r == (IW'(1) << nq_r);
  assign qualify  = ((idx_x & tbit) == '0) && ((idx_x & mask) == want);

  cqg_ram #(.AW(LOG_AMPS), .DW(2 * AMP_W)) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  cqg_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a0    (a0_r),
    .a1    (ram_rd),
    .m00   (m00_r),
    .m01   (m01_r),
    .m10   (m10_r),
    .m11   (m11_r),
    .done  (mac_done),
    .res   (mac_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_READ) begin
            state_nxt = S_READ;
          end else if (in_data.cmd == CMD_APPLY && !reject) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_READ: state_nxt = S_IDLE;
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_IDLE;
        end else if (qualify) begin
          state_nxt = S_RD0;
        end
      end
      S_RD0: state_nxt = S_RD1;
      S_RD1: state_nxt = S_CALC;
      S_CALC: begin
        if (mac_done) begin
          state_nxt = S_WR1;
        end
      end
      S_WR1: state_nxt = S_SCAN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_wa    = idx_x[LOG_AMPS-1:0];
    ram_wd    = mac_res.q0;
    ram_ra    = idx_x[LOG_AMPS-1:0];
    mac_start = 1'b0;
    out_load  = 1'b0;
    out_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        ram_ra = addr_x[LOG_AMPS-1:0];
        ram_wa = addr_x[LOG_AMPS-1:0];
        ram_wd = '{im: in_data.in_im, re: in_data.in_re};
        if (accept) begin
          priority if (in_data.cmd == CMD_WRITE) begin
            ram_we       = 1'b1;
            out_load     = 1'b1;
            out_nxt.kind = KIND_WRITE;
          end else if (in_data.cmd == CMD_APPLY && reject) begin
            out_load     = 1'b1;
            out_nxt.kind = KIND_REJECT;
          end else begin
            out_load = 1'b0;
          end
        end
      end
      S_READ: begin
        out_load       = 1'b1;
        out_nxt.kind   = KIND_READ;
        out_nxt.out_re = ram_rd.re;
        out_nxt.out_im = ram_rd.im;
      end
      S_SCAN: begin
        if (scan_end) begin
          out_load          = 1'b1;
          out_nxt.kind      = KIND_APPLY;
          out_nxt.saturated = sat_r;
        end
      end
      S_RD0: ram_ra = pair_x[LOG_AMPS-1:0];
      S_RD1: mac_start = 1'b1;
      S_CALC: ram_we = mac_done;
      S_WR1: begin
        ram_we = 1'b1;
        ram_wa = pair_x[LOG_AMPS-1:0];
        ram_wd = mac_res.q1;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      nq_r        <= 4'd10;
      tgt_r       <= '0;
      cmask_r     <= '0;
      cval_r      <= '0;
      m00_r       <= GATE_DIAG_RESET;
      m01_r       <= '0;
      m10_r       <= '0;
      m11_r       <= GATE_DIAG_RESET;
      idx_r       <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_NUM_QUBITS: nq_r    <= cfg_data[3:0];
          REG_TARGET:     tgt_r   <= cfg_data[3:0];
          REG_CTRL_MASK:  cmask_r <= cfg_data[CTRL_W-1:0];
          REG_CTRL_VALUE: cval_r  <= cfg_data[CTRL_W-1:0];
          REG_GATE_M00:   m00_r   <= cfg_data;
          REG_GATE_M01:   m01_r   <= cfg_data;
          REG_GATE_M10:   m10_r   <= cfg_data;
          default:        m11_r   <= cfg_data;
        endcase
      end
      if (accept) begin
        idx_r <= '0;
        sat_r <= 1'b0;
      end else if ((state_r == S_SCAN && !scan_end && !qualify) || state_r == S_WR1) begin
        idx_r <= idx_r + IW'(1);
      end
      if (state_r == S_CALC && mac_done && mac_res.sat) begin
        sat_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (state_r == S_RD0) begin
      a0_r <= ram_rd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> out_free) else $error("transfer taken with result pending");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free) else $error("result overwritten");
  a_done_calc: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_CALC) else $error("mac done outside calc");
  a_rd1_calc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD1 |=> state_r == S_CALC) else $error("pair read sequence broken");
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_CALC || state_r == S_WR1))
    else $error("store write in wrong state");

endmodule

// File: rtl/cqg_ram.sv
// cqg_ram: amplitude store, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
module cqg_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rd
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

// File: rtl/cqg_mac.sv
// cqg_mac: one shared multiplier computes the 2x2 complex product of a pair
// depends on cqg_pkg
`timescale 1ns / 1ps
module cqg_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  cqg_pkg::amp_t                 a0,
  input  cqg_pkg::amp_t                 a1,
  input  logic [cqg_pkg::GATE_W-1:0]    m00,
  input  logic [cqg_pkg::GATE_W-1:0]    m01,
  input  logic [cqg_pkg::GATE_W-1:0]    m10,
  input  logic [cqg_pkg::GATE_W-1:0]    m11,
  output logic                          done,
  output cqg_pkg::mac_res_t             res
);
  import cqg_pkg::*;

  amp_t                  a0_r, a1_r;
  logic                  busy_r;
  logic [3:0]            step_r;
  logic                  pv_r;
  logic [3:0]            pstep_r;
  logic signed [17:0]    prod_r;
  logic signed [19:0]    acc_r;
  mac_res_t              res_r;
  logic                  done_r;

  logic [GATE_W-1:0]     gsel;
  logic signed [15:0]    gpart;
  amp_t                  asel;
  logic signed [AMP_W-1:0] apart;
  logic signed [31:0]    mult;
  logic signed [32:0]    rnd;
  logic                  neg;
  logic signed [19:0]    pterm;
  logic signed [19:0]    base;
  logic signed [19:0]    sum;
  logic signed [AMP_W-1:0] satv;
  logic                  ovf;

  always_comb begin
    if (step_r[1]) begin
      gsel = step_r[3] ? m11 : m01;
      asel = a1_r;
    end else begin
      gsel = step_r[3] ? m10 : m00;
      asel = a0_r;
    end
    gpart = step_r[0] ? gsel[31:16] : gsel[15:0];
    apart = (step_r[2] ^ step_r[0]) ? asel.im : asel.re;
    mult  = gpart * apart;
    rnd   = 33'(mult) + 33'sd16384;
    neg   = !pstep_r[2] && pstep_r[0];
    pterm = neg ? -20'(prod_r) : 20'(prod_r);
    base  = (pstep_r[1:0] == 2'd0) ? 20'sd0 : acc_r;
    sum   = base + pterm;
    ovf   = 1'b1;
    if (sum > 20'sd32767) begin
      satv = 16'sh7FFF;
    end else if (sum < -20'sd32768) begin
      satv = -16'sh8000;
    end else begin
      satv = sum[AMP_W-1:0];
      ovf  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= pv_r && (pstep_r == 4'hF);
      pv_r   <= busy_r;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'hF) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a0_r      <= a0;
      a1_r      <= a1;
      res_r.sat <= 1'b0;
    end
    pstep_r <= step_r;
    prod_r  <= rnd[32:15];
    if (pv_r) begin
      acc_r <= sum;
      if (pstep_r[1:0] == 2'd3) begin
        if (ovf) begin
          res_r.sat <= 1'b1;
        end
        unique case (pstep_r[3:2])
          2'd0: res_r.q0.re <= satv;
          2'd1: res_r.q0.im <= satv;
          2'd2: res_r.q1.re <= satv;
          default: res_r.q1.im <= satv;
        endcase
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r && !pv_r) else $error("mac started while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("mac done held");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r) else $error("mac done while busy");

endmodule

// File: sim/controlled_one_qubit_gate_apply_top_tb.sv
// controlled_one_qubit_gate_apply_top_tb: randomized check of the controlled one-qubit gate block
// a scoreboard class predicts every result of write, read and apply, bursty sender, stalling receiver
// depends on cqg_pkg and controlled_one_qubit_gate_apply_top
`timescale 1ns / 1ps
module controlled_one_qubit_gate_apply_top_tb;
  import cqg_pkg::*;

  localparam int NAMPS = 1024;
  localparam int FILL = 256;
  localparam longint CYCLE_LIMIT = 3000000;

  class gate_scoreboard;
    amp_t amps[NAMPS];
    logic [3:0] nq, tgt;
    logic [CTRL_W-1:0] cmask, cval;
    logic [GATE_W-1:0] g00, g01, g10, g11;
    out_item_t pending[$];
    int errs;

    function new();
      nq = 4'd10;
      tgt = 4'd0;
      cmask = '0;
      cval = '0;
      g00 = GATE_DIAG_RESET;
      g01 = '0;
      g10 = '0;
      g11 = GATE_DIAG_RESET;
      errs = 0;
      foreach (amps[i]) amps[i] = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [GATE_W-1:0] v);
      case (idx)
        REG_NUM_QUBITS: nq = v[3:0];
        REG_TARGET:     tgt = v[3:0];
        REG_CTRL_MASK:  cmask = v[CTRL_W-1:0];
        REG_CTRL_VALUE: cval = v[CTRL_W-1:0];
        REG_GATE_M00:   g00 = v;
        REG_GATE_M01:   g01 = v;
        REG_GATE_M10:   g10 = v;
        REG_GATE_M11:   g11 = v;
        default: ;
      endcase
    endfunction

    function longint rprod(longint g, longint a);
      return (g * a + 64'sd16384) >>> 15;
    endfunction

    function logic signed [AMP_W-1:0] clamp(longint v, inout bit flag);
      if (v > 32767) begin
        flag = 1;
        return 16'sh7FFF;
      end
      if (v < -32768) begin
        flag = 1;
        return 16'sh8000;
      end
      return v[AMP_W-1:0];
    endfunction

    function amp_t mat_row(logic [GATE_W-1:0] ga, logic [GATE_W-1:0] gb, amp_t a0, amp_t a1,
                           inout bit flag);
      longint ar, ai, br, bi, r, im;
      amp_t res;
      ar = longint'($signed(ga[15:0]));
      ai = longint'($signed(ga[31:16]));
      br = longint'($signed(gb[15:0]));
      bi = longint'($signed(gb[31:16]));
      r = rprod(ar, a0.re) - rprod(ai, a0.im) + rprod(br, a1.re) - rprod(bi, a1.im);
      im = rprod(ar, a0.im) + rprod(ai, a0.re) + rprod(br, a1.im) + rprod(bi, a1.re);
      res.re = clamp(r, flag);
      res.im = clamp(im, flag);
      return res;
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      int count, tbit, msk, want;
      bit flag;
      amp_t a0, a1;
      e = '0;
      flag = 0;
      case (cmd_t'(it.cmd))
        CMD_WRITE: begin
          amps[it.address].re = it.in_re;
          amps[it.address].im = it.in_im;
          e.kind = KIND_WRITE;
          pending.push_back(e);
        end
        CMD_READ: begin
          e.kind = KIND_READ;
          e.out_re = amps[it.address].re;
          e.out_im = amps[it.address].im;
          pending.push_back(e);
        end
        CMD_APPLY: begin
          if (nq > 10 || tgt >= nq) begin
            e.kind = KIND_REJECT;
          end else begin
            count = 1 << nq;
            tbit = 1 << tgt;
            msk = int'(cmask) & ~tbit;
            want = int'(cval) & msk;
            for (int i0 = 0; i0 < count; i0++) begin
              if ((i0 & tbit) != 0 || (i0 & msk) != want) continue;
              a0 = amps[i0];
              a1 = amps[i0 | tbit];
              amps[i0] = mat_row(g00, g01, a0, a1, flag);
              amps[i0 | tbit] = mat_row(g10, g11, a0, a1, flag);
            end
            e.kind = KIND_APPLY;
            e.saturated = flag;
          end
          pending.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d", got.kind);
        errs++;
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, got.kind);
        errs++;
      end
      if (got.out_re !== e.out_re) begin
        $error("out_re: expected %0d actual %0d", e.out_re, got.out_re);
        errs++;
      end
      if (got.out_im !== e.out_im) begin
        $error("out_im: expected %0d actual %0d", e.out_im, got.out_im);
        errs++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated: expected %0d actual %0d", e.saturated, got.saturated);
        errs++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GATE_W-1:0] cfg_data;

  gate_scoreboard sb;
  longint cycles = 0;
  int burst_left;
  int stall_mode = 0;
  int stall_cnt = 0;

  controlled_one_qubit_gate_apply_top u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  // receiver: check each result transfer, stall on a shifting pattern
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("controlled_one_qubit_gate_apply_top_tb: FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= (stall_cnt % 16) < 9;
      default: out_stall <= ($urandom_range(0, 5) != 0);
    endcase
  end

  task automatic send_item(in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [GATE_W-1:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(logic [3:0] nq, logic [3:0] tg, logic [9:0] m, logic [9:0] v,
                         logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    drain();
    write_reg(REG_NUM_QUBITS, 32'(nq));
    write_reg(REG_TARGET, 32'(tg));
    write_reg(REG_CTRL_MASK, 32'(m));
    write_reg(REG_CTRL_VALUE, 32'(v));
    write_reg(REG_GATE_M00, a);
    write_reg(REG_GATE_M01, b);
    write_reg(REG_GATE_M10, c);
    write_reg(REG_GATE_M11, d);
  endtask

  function automatic in_item_t mk(cmd_t c, logic [9:0] a, logic [15:0] r, logic [15:0] i);
    in_item_t it;
    it.cmd = c;
    it.address = a;
    it.in_re = r;
    it.in_im = i;
    return it;
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'h8000_8000;
      1: return 32'h7FFF_7FFF;
      2: return 32'h0000_7FFF;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(int n);
    int ap;
    in_item_t it;
    ap = (sb.nq >= 8 && sb.nq <= 10) ? 1 : 15;
    for (int k = 0; k < n; k++) begin
      it = mk(CMD_WRITE, 10'($urandom_range(0, FILL - 1)), 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 99) < ap) it.cmd = CMD_APPLY;
      else if ($urandom_range(0, 19) == 0) it.cmd = CMD_NONE;
      else it.cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
      send_item(it);
    end
  endtask

  initial begin
    logic [3:0] nq, tg;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the low part of the store; reads and sweeps stay inside it
    for (int a = 0; a < FILL; a++) begin
      send_item(mk(CMD_WRITE, a[9:0], 16'($urandom), 16'($urandom)));
    end

    send_item(mk(CMD_WRITE, 10'd0, 16'h8000, 16'h8000));
    send_item(mk(CMD_WRITE, 10'd255, 16'h7FFF, 16'h7FFF));
    send_item(mk(CMD_WRITE, 10'd1, 16'h7FFF, 16'h8000));
    send_item(mk(CMD_READ, 10'd0, 16'h0, 16'h0));
    send_item(mk(CMD_READ, 10'd255, 16'hFFFF, 16'hFFFF));
    send_item(mk(CMD_NONE, 10'd5, 16'h1234, 16'h4321));
    // matrix at reset values, sweep over the filled part
    drain();
    write_reg(REG_NUM_QUBITS, 32'd8);
    send_item(mk(CMD_APPLY, 10'd0, 16'h0, 16'h0));
    send_item(mk(CMD_READ, 10'd0, 16'h0, 16'h0));
    send_item(mk(CMD_READ, 10'd1, 16'h0, 16'h0));

    // target at or above num_qubits, and num_qubits beyond the store
    set_all(4'd3, 4'd3, 10'd0, 10'd0, 32'h7FFF_0000, 32'h0, 32'h0, 32'h7FFF_0000);
    send_item(mk(CMD_APPLY, 10'd0, 16'h0, 16'h0));
    set_all(4'd15, 4'd9, 10'd0, 10'd0, 32'h7FFF_0000, 32'h0, 32'h0, 32'h7FFF_0000);
    send_item(mk(CMD_APPLY, 10'd0, 16'h0, 16'h0));
    // target inside the mask, extreme matrix to force saturation
    set_all(4'd4, 4'd0, 10'h3FF, 10'h3FE, 32'h8000_8000, 32'h8000_8000, 32'h7FFF_7FFF,
            32'h8000_8000);
    send_item(mk(CMD_APPLY, 10'd0, 16'h0, 16'h0));
    send_item(mk(CMD_READ, 10'd14, 16'h0, 16'h0));
    send_item(mk(CMD_READ, 10'd15, 16'h0, 16'h0));
    // control bit above the sweep that can never match
    set_all(4'd2, 4'd1, 10'h200, 10'h3FF, 32'h0, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h0);
    send_item(mk(CMD_APPLY, 10'd0, 16'h0, 16'h0));
    send_item(mk(CMD_READ, 10'd2, 16'h0, 16'h0));
    // top target of the filled part, one qubit
    set_all(4'd8, 4'd7, 10'h1FF, 10'h0AB, 32'h5A82_5A82, 32'h5A82_0000, 32'h0, 32'h8000_0000);
    send_item(mk(CMD_APPLY, 10'd0, 16'h0, 16'h0));
    set_all(4'd1, 4'd0, 10'd0, 10'd0, 32'h0, 32'h7FFF, 32'h7FFF, 32'h0);
    send_item(mk(CMD_APPLY, 10'd0, 16'h0, 16'h0));
    send_item(mk(CMD_READ, 10'd1, 16'h0, 16'h0));

    for (int ph = 0; ph < 15; ph++) begin
      case ($urandom_range(0, 9))
        0: nq = 4'd8;
        1: nq = $urandom_range(11, 15);
        default: nq = $urandom_range(1, 5);
      endcase
      tg = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) :
           4'($urandom_range(0, (nq > 10 ? 7 : nq - 1)));
      set_all(nq, tg, ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom),
              10'($urandom), rand_elem(), rand_elem(), rand_elem(), rand_elem());
      random_items(22);
    end

    drain();
    if (sb.errs == 0 && sb.pending.size() == 0) begin
      $display("controlled_one_qubit_gate_apply_top_tb: PASS");
    end else begin
      $display("controlled_one_qubit_gate_apply_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cqg_pkg.sv
rtl/cqg_ram.sv
rtl/cqg_mac.sv
rtl/controlled_one_qubit_gate_apply_top.sv
sim/controlled_one_qubit_gate_apply_top_tb.sv
